// ----- rtl/core/bpc_pkg.sv -----
// shared types, constants and helpers for the barometer compensation pipeline
package bpc_pkg;

    localparam int unsigned COEF_W    = 16;
    localparam int unsigned RAW_W     = 24;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_C1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_C4 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C5 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C6 = 3'd5;

    localparam logic signed [18:0] TREF_CENTI = 19'sd2000;
    localparam logic signed [18:0] TLOW_CENTI = -19'sd1500;

    localparam logic [5:0]  OFF2_A_MUL  = 6'd61;
    localparam logic [4:0]  OFF2_B_MUL  = 5'd20;
    localparam logic [3:0]  SENS2_B_MUL = 4'd12;

    localparam int unsigned TEMP_SHIFT  = 23;
    localparam int unsigned OFF_SHIFT   = 6;
    localparam int unsigned SENS_SHIFT  = 7;
    localparam int unsigned PROD_SHIFT  = 21;
    localparam int unsigned PRES_SHIFT  = 15;

    localparam logic signed [63:0] PRES_MAX = 64'sd2147483647;
    localparam logic signed [63:0] PRES_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [COEF_W-1:0] c1;
        logic [COEF_W-1:0] c2;
        logic [COEF_W-1:0] c3;
        logic [COEF_W-1:0] c4;
        logic [COEF_W-1:0] c5;
        logic [COEF_W-1:0] c6;
    } coef_t;

    typedef struct packed {
        logic signed [18:0] q;
        logic [16:0]        t2;
        logic signed [39:0] off1;
        logic signed [39:0] sens1;
        logic [RAW_W-1:0]   d1;
        logic [RAW_W-1:0]   d2;
    } fo_data_t;

    typedef struct packed {
        logic signed [18:0] temp;
        logic signed [43:0] off;
        logic signed [41:0] sens;
        logic [RAW_W-1:0]   d1;
        logic [RAW_W-1:0]   d2;
    } so_data_t;

    // arithmetic shift right that rounds toward zero
    function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] v,
                                                     input int unsigned k);
        logic signed [63:0] bias;
        bias = (64'sd1 <<< k) - 64'sd1;
        if (v < 64'sd0)
        begin
            shr_trunc = (v + bias) >>> k;
        end
        else
        begin
            shr_trunc = v >>> k;
        end
    endfunction

endpackage

// ----- rtl/core/bpc_first_order.sv -----
// first-order stages: dt, calibration products, base temperature, offset and sensitivity
module bpc_first_order (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpc_pkg::coef_t                coef,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bpc_pkg::RAW_W-1:0]     raw_pressure,
    input  logic [bpc_pkg::RAW_W-1:0]     raw_temperature,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bpc_pkg::fo_data_t             out_data
);

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    logic signed [24:0] dt_next, dt_reg, s2_dt_unused;
    logic [bpc_pkg::RAW_W-1:0] s1_d1_reg, s1_d2_reg, s2_d1_reg, s2_d2_reg;

    logic signed [41:0] p6_next, p6_reg;
    logic signed [41:0] p4_next, p4_reg;
    logic signed [41:0] p3_next, p3_reg;
    logic [47:0]        dtsq_next, dtsq_reg;

    bpc_pkg::fo_data_t fo_next, fo_reg;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;
    assign out_valid = v3_reg;
    assign out_data  = fo_reg;

    assign dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, coef.c5, 8'd0});
    assign s2_dt_unused = dt_reg;

    assign p6_next   = 42'(dt_reg) * 42'($signed({1'b0, coef.c6}));
    assign p4_next   = 42'(dt_reg) * 42'($signed({1'b0, coef.c4}));
    assign p3_next   = 42'(dt_reg) * 42'($signed({1'b0, coef.c3}));
    assign dtsq_next = 48'(dt_reg) * 48'(s2_dt_unused);

    always_comb
    begin
        fo_next.q     = 19'(bpc_pkg::shr_trunc(64'(p6_reg), bpc_pkg::TEMP_SHIFT));
        fo_next.t2    = dtsq_reg[47:31];
        fo_next.off1  = $signed({7'd0, coef.c2, 17'd0})
                      + 40'(bpc_pkg::shr_trunc(64'(p4_reg), bpc_pkg::OFF_SHIFT));
        fo_next.sens1 = $signed({8'd0, coef.c1, 16'd0})
                      + 40'(bpc_pkg::shr_trunc(64'(p3_reg), bpc_pkg::SENS_SHIFT));
        fo_next.d1    = s2_d1_reg;
        fo_next.d2    = s2_d2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            dt_reg    <= dt_next;
            s1_d1_reg <= raw_pressure;
            s1_d2_reg <= raw_temperature;
        end
        if (en2)
        begin
            p6_reg    <= p6_next;
            p4_reg    <= p4_next;
            p3_reg    <= p3_next;
            dtsq_reg  <= dtsq_next;
            s2_d1_reg <= s1_d1_reg;
            s2_d2_reg <= s1_d2_reg;
        end
        if (en3)
        begin
            fo_reg <= fo_next;
        end
    end

endmodule

// ----- rtl/core/bpc_second_order.sv -----
// second-order stages: squared temperature deltas and corrected temperature, offset, sensitivity
module bpc_second_order (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bpc_pkg::fo_data_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bpc_pkg::so_data_t out_data
);

    logic v4_reg, v5_reg;
    logic en4, en5;

    logic signed [19:0] b_val;
    logic [35:0]        sq_a_next, sq_a_reg;
    logic [35:0]        sq_b_next, sq_b_reg;
    logic               lt_ref_next, lt_ref_reg;
    logic               lt_low_next, lt_low_reg;
    logic signed [18:0] t1_next, t1_reg;
    logic [16:0]        t2_reg;
    logic signed [39:0] off1_reg, sens1_reg;
    logic [bpc_pkg::RAW_W-1:0] d1_reg, d2_reg;

    logic [41:0] off2;
    logic [39:0] sens2;
    bpc_pkg::so_data_t so_next, so_reg;

    assign en5       = !v5_reg || out_ready;
    assign en4       = !v4_reg || en5;
    assign in_ready  = en4;
    assign out_valid = v5_reg;
    assign out_data  = so_reg;

    // q is the first-order temperature minus the reference point
    assign b_val       = 20'(in_data.q) + 20'(bpc_pkg::TREF_CENTI - bpc_pkg::TLOW_CENTI);
    assign sq_a_next   = 36'(in_data.q) * 36'(in_data.q);
    assign sq_b_next   = 36'(b_val) * 36'(b_val);
    assign lt_ref_next = in_data.q[18];
    assign lt_low_next = in_data.q < (bpc_pkg::TLOW_CENTI - bpc_pkg::TREF_CENTI);
    assign t1_next     = in_data.q + bpc_pkg::TREF_CENTI;

    always_comb
    begin
        off2  = 42'd0;
        sens2 = 40'd0;
        if (lt_ref_reg)
        begin
            off2  = (42'(sq_a_reg) * 42'(bpc_pkg::OFF2_A_MUL)) >> 4;
            sens2 = {3'd0, sq_a_reg, 1'b0};
        end
        if (lt_low_reg)
        begin
            off2  = off2 + 42'(sq_b_reg) * 42'(bpc_pkg::OFF2_B_MUL);
            sens2 = sens2 + 40'(sq_b_reg) * 40'(bpc_pkg::SENS2_B_MUL);
        end
        so_next.temp = t1_reg - (lt_ref_reg ? $signed({2'b0, t2_reg}) : 19'sd0);
        so_next.off  = 44'(off1_reg) - $signed({2'b0, off2});
        so_next.sens = 42'(sens1_reg) - $signed({2'b0, sens2});
        so_next.d1   = d1_reg;
        so_next.d2   = d2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en4)
            begin
                v4_reg <= in_valid;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            sq_a_reg   <= sq_a_next;
            sq_b_reg   <= sq_b_next;
            lt_ref_reg <= lt_ref_next;
            lt_low_reg <= lt_low_next;
            t1_reg     <= t1_next;
            t2_reg     <= in_data.t2;
            off1_reg   <= in_data.off1;
            sens1_reg  <= in_data.sens1;
            d1_reg     <= in_data.d1;
            d2_reg     <= in_data.d2;
        end
        if (en5)
        begin
            so_reg <= so_next;
        end
    end

endmodule

// ----- rtl/core/bpc_pressure.sv -----
// pressure stages: split sensitivity product, scaling, offset removal and saturation
module bpc_pressure (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  bpc_pkg::so_data_t         in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [18:0]        temperature_centi,
    output logic signed [31:0]        pressure_pa,
    output logic [bpc_pkg::RAW_W-1:0] echo_pressure,
    output logic [bpc_pkg::RAW_W-1:0] echo_temperature
);

    logic v6_reg, v7_reg, v8_reg, v9_reg;
    logic en6, en7, en8, en9;

    logic [20:0]        sens_lo;
    logic signed [20:0] sens_hi;
    logic [44:0]        pl_next, pl_reg;
    logic signed [45:0] ph_next, ph_reg;
    logic signed [63:0] prod_next, prod_reg;
    logic signed [45:0] y_next, y_reg;
    logic signed [63:0] z_val;
    logic signed [31:0] pres_next, pres_reg;

    logic signed [43:0] off6_reg, off7_reg;
    logic signed [18:0] t6_reg, t7_reg, t8_reg, t9_reg;
    logic [bpc_pkg::RAW_W-1:0] p6_reg, p7_reg, p8_reg, p9_reg;
    logic [bpc_pkg::RAW_W-1:0] r6_reg, r7_reg, r8_reg, r9_reg;

    assign en9       = !v9_reg || out_ready;
    assign en8       = !v8_reg || en9;
    assign en7       = !v7_reg || en8;
    assign en6       = !v6_reg || en7;
    assign in_ready  = en6;
    assign out_valid = v9_reg;

    assign temperature_centi = t9_reg;
    assign pressure_pa       = pres_reg;
    assign echo_pressure     = p9_reg;
    assign echo_temperature  = r9_reg;

    // d1 * sens as two 24 x 21 partial products
    assign sens_lo   = in_data.sens[20:0];
    assign sens_hi   = in_data.sens[41:21];
    assign pl_next   = 45'(in_data.d1) * 45'(sens_lo);
    assign ph_next   = 46'($signed({1'b0, in_data.d1})) * 46'(sens_hi);
    assign prod_next = (64'(ph_reg) <<< 21) + $signed({19'd0, pl_reg});
    assign y_next    = 46'(bpc_pkg::shr_trunc(prod_reg, bpc_pkg::PROD_SHIFT)) - 46'(off7_reg);
    assign z_val     = bpc_pkg::shr_trunc(64'(y_reg), bpc_pkg::PRES_SHIFT);

    always_comb
    begin
        if (z_val > bpc_pkg::PRES_MAX)
        begin
            pres_next = 32'(bpc_pkg::PRES_MAX);
        end
        else if (z_val < bpc_pkg::PRES_MIN)
        begin
            pres_next = 32'(bpc_pkg::PRES_MIN);
        end
        else
        begin
            pres_next = 32'(z_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else
        begin
            if (en6)
            begin
                v6_reg <= in_valid;
            end
            if (en7)
            begin
                v7_reg <= v6_reg;
            end
            if (en8)
            begin
                v8_reg <= v7_reg;
            end
            if (en9)
            begin
                v9_reg <= v8_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            off6_reg <= in_data.off;
            t6_reg   <= in_data.temp;
            p6_reg   <= in_data.d1;
            r6_reg   <= in_data.d2;
        end
        if (en7)
        begin
            prod_reg <= prod_next;
            off7_reg <= off6_reg;
            t7_reg   <= t6_reg;
            p7_reg   <= p6_reg;
            r7_reg   <= r6_reg;
        end
        if (en8)
        begin
            y_reg  <= y_next;
            t8_reg <= t7_reg;
            p8_reg <= p7_reg;
            r8_reg <= r7_reg;
        end
        if (en9)
        begin
            pres_reg <= pres_next;
            t9_reg   <= t8_reg;
            p9_reg   <= p8_reg;
            r9_reg   <= r8_reg;
        end
    end

endmodule

// ----- rtl/core/baro_pressure_compensation.sv -----
// top level: calibration registers and the nine-stage compensation pipeline
//
//   channel  handshake             payload
//   in       in_valid / in_stall   raw_pressure, raw_temperature
//   out      out_valid / out_stall temperature_centi, pressure_pa, echo_pressure,
//                                  echo_temperature
//   cfg      cfg_write_en          cfg_index, cfg_data
//
// one word per cycle while in_stall is low; an accepted word passes the nine
// register stages (three first-order, two second-order, four pressure) before
// out_valid rises for it
// reset clears stage valids and all calibration words to zero
// a stalled output holds the last stage; empty stages ahead of it keep filling,
// so up to eight more words are accepted before in_stall rises
module baro_pressure_compensation (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bpc_pkg::COEF_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bpc_pkg::RAW_W-1:0]     raw_pressure,
    input  logic [bpc_pkg::RAW_W-1:0]     raw_temperature,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [18:0]            temperature_centi,
    output logic signed [31:0]            pressure_pa,
    output logic [bpc_pkg::RAW_W-1:0]     echo_pressure,
    output logic [bpc_pkg::RAW_W-1:0]     echo_temperature
);

    bpc_pkg::coef_t    coef_reg, coef_next;
    bpc_pkg::fo_data_t fo_data;
    bpc_pkg::so_data_t so_data;
    logic              in_ready;
    logic              fo_valid, fo_ready;
    logic              so_valid, so_ready;

    assign in_stall = !in_ready;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                bpc_pkg::REG_C1: coef_next.c1 = cfg_data;
                bpc_pkg::REG_C2: coef_next.c2 = cfg_data;
                bpc_pkg::REG_C3: coef_next.c3 = cfg_data;
                bpc_pkg::REG_C4: coef_next.c4 = cfg_data;
                bpc_pkg::REG_C5: coef_next.c5 = cfg_data;
                bpc_pkg::REG_C6: coef_next.c6 = cfg_data;
                default: coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    bpc_first_order u_first (
        .clk             (clk),
        .rst_n           (rst_n),
        .coef            (coef_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .raw_pressure    (raw_pressure),
        .raw_temperature (raw_temperature),
        .out_valid       (fo_valid),
        .out_ready       (fo_ready),
        .out_data        (fo_data)
    );

    bpc_second_order u_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fo_valid),
        .in_ready  (fo_ready),
        .in_data   (fo_data),
        .out_valid (so_valid),
        .out_ready (so_ready),
        .out_data  (so_data)
    );

    bpc_pressure u_pressure (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (so_valid),
        .in_ready          (so_ready),
        .in_data           (so_data),
        .out_valid         (out_valid),
        .out_ready         (!out_stall),
        .temperature_centi (temperature_centi),
        .pressure_pa       (pressure_pa),
        .echo_pressure     (echo_pressure),
        .echo_temperature  (echo_temperature)
    );

endmodule
